// ----- src/psq_pkg.sv -----
package psq_pkg;

   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_FWD   = 3'd1;
   localparam logic [2:0] CMD_BWD   = 3'd2;
   localparam logic [2:0] CMD_CYCLE = 3'd3;
   localparam logic [2:0] CMD_GOTO  = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_POS = 2'd1;
   localparam logic [1:0] ST_BUSY    = 2'd2;

   localparam logic [1:0] MODE_WAVE = 2'd0;
   localparam logic [1:0] MODE_TWO  = 2'd1;
   localparam logic [1:0] MODE_HALF = 2'd2;
   localparam logic [1:0] MODE_NONE = 2'd3;

   localparam logic [1:0] REG_STEP_MODE   = 2'd0;
   localparam logic [1:0] REG_HOLD_ENABLE = 2'd1;
   localparam logic [1:0] REG_PULSE_TICKS = 2'd2;

   localparam logic [15:0] PULSE_TICKS_RESET = 16'd10;

   typedef struct packed {
      logic [2:0]         command;
      logic [15:0]        step_count;
      logic signed [11:0] cycles;
      logic [2:0]         target_position;
   } psq_req_type;

   typedef struct packed {
      logic [3:0] coil_drive;
      logic [2:0] current_position;
      logic       moving;
      logic [1:0] status;
   } psq_rsp_type;

   typedef struct packed {
      logic [1:0]  step_mode;
      logic        hold_enable;
      logic [15:0] pulse_ticks;
   } psq_cfg_type;

   // coil bits: bit0 A, bit1 B, bit2 C, bit3 D
   function automatic logic [3:0] coil_pattern(input logic [2:0] pos);
      logic [3:0] pat;
      case (pos)
         3'd0: pat = 4'd1;
         3'd1: pat = 4'd5;
         3'd2: pat = 4'd4;
         3'd3: pat = 4'd6;
         3'd4: pat = 4'd2;
         3'd5: pat = 4'd10;
         3'd6: pat = 4'd8;
         default: pat = 4'd9;
      endcase
      return pat;
   endfunction

   function automatic logic pos_in_mode(input logic [1:0] mode, input logic [2:0] pos);
      logic ok;
      case (mode)
         MODE_WAVE: ok = ~pos[0];
         MODE_TWO:  ok = pos[0];
         MODE_HALF: ok = 1'b1;
         default:   ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

// ----- src/psq_csr.sv -----
module psq_csr
   import psq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output psq_cfg_type cfg
);

   psq_cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_STEP_MODE:   cfg_in.step_mode   = csr_wdata[1:0];
            REG_HOLD_ENABLE: cfg_in.hold_enable = csr_wdata[0];
            REG_PULSE_TICKS: cfg_in.pulse_ticks = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_mode   <= MODE_WAVE;
         cfg_ff.hold_enable <= 1'b0;
         cfg_ff.pulse_ticks <= PULSE_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/psq_engine.sv -----
module psq_engine
   import psq_pkg::*;
#(
   parameter int COUNT_BITS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  psq_cfg_type cfg,
   input  logic        fire,
   input  psq_req_type item,
   output psq_rsp_type result
);

   localparam int WIDE = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   logic [2:0]            ring_ff, ring_in;
   logic [COUNT_BITS-1:0] steps_ff, steps_in;
   logic                  dir_ff, dir_in;
   logic [15:0]           pulse_ff, pulse_in;
   logic [3:0]            coil_ff, coil_in;

   logic [1:0]            status;
   logic                  busy;
   logic [2:0]            stride;
   logic [15:0]           pulse_load;
   logic [15:0]           pulse_dec;
   logic [11:0]           mag;
   logic                  neg;
   logic [15:0]           cnt16;
   logic [WIDE-1:0]       cnt_wide;
   logic [COUNT_BITS-1:0] cnt_n;
   logic                  step_req;
   logic                  abort_req;
   logic [2:0]            step_pos;

   assign busy       = (steps_ff != '0) || (pulse_ff != '0);
   assign stride     = (cfg.step_mode == MODE_HALF) ? 3'd1 : 3'd2;
   assign pulse_load = (cfg.pulse_ticks == '0) ? 16'd1 : cfg.pulse_ticks;
   assign pulse_dec  = pulse_ff - 16'd1;
   assign neg        = item.cycles[11];
   assign mag        = neg ? (12'd0 - item.cycles) : item.cycles;

   always_comb begin
      if (item.command == CMD_CYCLE) begin
         cnt16 = (cfg.step_mode == MODE_HALF) ? {1'b0, mag, 3'b000} : {2'b00, mag, 2'b00};
      end else begin
         cnt16 = item.step_count;
      end
      cnt_wide = WIDE'(cnt16);
      // saturate at the counter's full scale
      if (cnt_wide > WIDE'({COUNT_BITS{1'b1}})) begin
         cnt_n = {COUNT_BITS{1'b1}};
      end else begin
         cnt_n = cnt_wide[COUNT_BITS-1:0];
      end
   end

   always_comb begin
      ring_in   = ring_ff;
      steps_in  = steps_ff;
      dir_in    = dir_ff;
      pulse_in  = pulse_ff;
      coil_in   = coil_ff;
      status    = ST_OK;
      step_req  = 1'b0;
      abort_req = 1'b0;
      step_pos  = '0;

      if (item.command == CMD_TICK) begin
         if (pulse_ff != '0) begin
            pulse_in = pulse_dec;
            if (pulse_dec == '0) begin
               if (steps_ff != '0) begin
                  steps_in = steps_ff - COUNT_BITS'(1);
                  step_req = 1'b1;
               end else if (!cfg.hold_enable) begin
                  coil_in = '0;
               end
            end
         end
      end else if (item.command inside {CMD_FWD, CMD_BWD, CMD_CYCLE, CMD_GOTO} && busy) begin
         status = ST_BUSY;
      end else begin
         case (item.command)
            CMD_FWD, CMD_BWD, CMD_CYCLE: begin
               if (item.command == CMD_CYCLE && cfg.step_mode == MODE_NONE) begin
                  abort_req = 1'b1;
                  status    = ST_BAD_POS;
               end else if (cnt_n != '0) begin
                  if (item.command == CMD_CYCLE) begin
                     dir_in = neg || (mag == '0);
                  end else begin
                     dir_in = (item.command == CMD_BWD);
                  end
                  steps_in = cnt_n - COUNT_BITS'(1);
                  step_req = 1'b1;
               end
            end
            CMD_GOTO: begin
               if (pos_in_mode(cfg.step_mode, item.target_position)) begin
                  steps_in = '0;
                  ring_in  = item.target_position;
                  coil_in  = coil_pattern(item.target_position);
                  pulse_in = pulse_load;
               end else begin
                  abort_req = 1'b1;
                  status    = ST_BAD_POS;
               end
            end
            default: ;
         endcase
      end

      step_pos = dir_in ? (ring_ff - stride) : (ring_ff + stride);
      if (step_req) begin
         if (pos_in_mode(cfg.step_mode, ring_ff)) begin
            ring_in  = step_pos;
            coil_in  = coil_pattern(step_pos);
            pulse_in = pulse_load;
         end else begin
            abort_req = 1'b1;
            status    = ST_BAD_POS;
         end
      end

      // drop the rest of the move
      if (abort_req) begin
         steps_in = '0;
         pulse_in = '0;
         if (!cfg.hold_enable) begin
            coil_in = '0;
         end
      end

      result.coil_drive       = coil_in;
      result.current_position = ring_in;
      result.moving           = (steps_in != '0) || (pulse_in != '0);
      result.status           = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff  <= '0;
         steps_ff <= '0;
         dir_ff   <= 1'b0;
         pulse_ff <= '0;
         coil_ff  <= '0;
      end else if (fire) begin
         ring_ff  <= ring_in;
         steps_ff <= steps_in;
         dir_ff   <= dir_in;
         pulse_ff <= pulse_in;
         coil_ff  <= coil_in;
      end
   end

endmodule

// ----- src/stepper_phase_sequencer.sv -----
// Four-coil unipolar stepper sequencer over an eight-position ring.
// req channel: one item per tick or command (tick, forward, backward, cycle,
//   goto). rsp channel: exactly one result per item, in order, giving coil
//   drive, ring position, moving flag and status.
// csr channel: register writes (0 step_mode, 1 hold_enable, 2 pulse_ticks),
//   always ready, taken in the cycle they are presented; write only while idle.
// Throughput: one item per cycle sustained while rsp_ready stays high. An
//   accepted item is held in the input register, where the state update is
//   computed, and its result is then written to the output register, which
//   drives rsp_valid and rsp_item.
// When the receiver stalls, the result holds in the output register; one
//   more item may wait in the input register, after which req_ready drops
//   until rsp_ready returns.
// Reset (synchronous, active high) empties both registers, puts the ring at
//   position A with all coils off and no move pending, and loads the
//   register defaults (wave mode, no hold, 10 ticks per pulse).
// COUNT_BITS sets the width of the remaining-step counter; longer requests
//   saturate at its full scale.
module stepper_phase_sequencer
   import psq_pkg::*;
#(
   parameter int COUNT_BITS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  psq_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output psq_rsp_type rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   psq_cfg_type cfg;
   psq_rsp_type result;

   logic        in_valid_ff;
   psq_req_type in_item_ff;
   logic        out_valid_ff;
   psq_rsp_type out_item_ff;
   logic        advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   psq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   psq_engine #(
      .COUNT_BITS (COUNT_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

endmodule

// ----- verif/tb_stepper_phase_sequencer.sv -----
module tb_stepper_phase_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   import psq_pkg::*;

   localparam logic [1:0] REG_SPARE      = 2'd3;
   localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
   localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;
   localparam int unsigned COUNT_MAX     = 65535;
   localparam int RANDOM_ITEMS           = 1700;
   localparam int LONG_PULSE             = 40;
   localparam int SETTLE_CYCLES          = 3;
   localparam int CALM_START             = 1000;
   localparam int CALM_END               = 1600;
   localparam int CYCLE_LIMIT            = 1500000;

   // Tracks the sequencer state and queues the coil/position result of each item.
   class coil_tracker;
      logic [1:0]  mode_cfg;
      logic        hold_cfg;
      logic [15:0] pulse_cfg;
      logic [2:0]  pos;
      int unsigned steps_left;
      logic        reverse;
      logic [15:0] pulse_left;
      logic [3:0]  coils;
      psq_rsp_type expected_q[$];
      int unsigned mismatches;

      function new();
         mode_cfg   = MODE_WAVE;
         hold_cfg   = 1'b0;
         pulse_cfg  = PULSE_TICKS_RESET;
         pos        = 3'd0;
         steps_left = 0;
         reverse    = 1'b0;
         pulse_left = 16'd0;
         coils      = 4'd0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] data);
         case (idx)
            REG_STEP_MODE:   mode_cfg = data[1:0];
            REG_HOLD_ENABLE: hold_cfg = data[0];
            REG_PULSE_TICKS: pulse_cfg = data;
            default: ;
         endcase
      endfunction

      function bit fits_mode(logic [2:0] p);
         case (mode_cfg)
            MODE_WAVE: return !p[0];
            MODE_TWO:  return p[0];
            MODE_HALF: return 1'b1;
            default:   return 1'b0;
         endcase
      endfunction

      function bit is_moving();
         return (steps_left != 0) || (pulse_left != 16'd0);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function logic [3:0] coil_bits(logic [2:0] p);
         case (p)
            3'd0: return 4'd1;
            3'd1: return 4'd5;
            3'd2: return 4'd4;
            3'd3: return 4'd6;
            3'd4: return 4'd2;
            3'd5: return 4'd10;
            3'd6: return 4'd8;
            default: return 4'd9;
         endcase
      endfunction

      function void energise(logic [2:0] p);
         pos        = p;
         coils      = coil_bits(p);
         pulse_left = (pulse_cfg == 16'd0) ? 16'd1 : pulse_cfg;
      endfunction

      function void halt();
         steps_left = 0;
         pulse_left = 16'd0;
         if (!hold_cfg) coils = 4'd0;
      endfunction

      function bit step_once();
         logic [2:0] stride;
         stride = (mode_cfg == MODE_HALF) ? 3'd1 : 3'd2;
         if (!fits_mode(pos)) begin
            halt();
            return 1'b0;
         end
         energise(reverse ? pos - stride : pos + stride);
         return 1'b1;
      endfunction

      function logic [1:0] begin_move(int unsigned n, bit rev);
         if (n > COUNT_MAX) n = COUNT_MAX;
         if (n == 0) return ST_OK;
         reverse    = rev;
         steps_left = n - 1;
         return step_once() ? ST_OK : ST_BAD_POS;
      endfunction

      function void note_item(psq_req_type it);
         logic [1:0]  status;
         bit          busy;
         int          turns;
         int unsigned per;
         psq_rsp_type want;
         status = ST_OK;
         busy   = is_moving();
         if (it.command == CMD_TICK) begin
            if (pulse_left != 16'd0) begin
               pulse_left = pulse_left - 16'd1;
               if (pulse_left == 16'd0) begin
                  if (steps_left != 0) begin
                     steps_left = steps_left - 1;
                     if (!step_once()) status = ST_BAD_POS;
                  end else if (!hold_cfg) begin
                     coils = 4'd0;
                  end
               end
            end
         end else if (it.command <= CMD_GOTO) begin
            if (busy) begin
               status = ST_BUSY;
            end else begin
               case (it.command)
                  CMD_FWD, CMD_BWD: begin
                     status = begin_move(it.step_count, it.command == CMD_BWD);
                  end
                  CMD_CYCLE: begin
                     if (mode_cfg == MODE_NONE) begin
                        halt();
                        status = ST_BAD_POS;
                     end else begin
                        turns = $signed(it.cycles);
                        per = (mode_cfg == MODE_HALF) ? 8 : 4;
                        // zero cycles counts as backward, which leaves direction alone
                        status = begin_move((turns < 0 ? -turns : turns) * per, turns <= 0);
                     end
                  end
                  default: begin
                     if (fits_mode(it.target_position)) begin
                        steps_left = 0;
                        energise(it.target_position);
                     end else begin
                        halt();
                        status = ST_BAD_POS;
                     end
                  end
               endcase
            end
         end
         want.coil_drive       = coils;
         want.current_position = pos;
         want.moving           = is_moving();
         want.status           = status;
         expected_q.push_back(want);
      endfunction

      function void complain(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
      endfunction

      function void check_result(psq_rsp_type got);
         psq_rsp_type want;
         if (expected_q.size() == 0) begin
            complain($sformatf("unexpected result coils %h pos %0d moving %b status %0d",
                               got.coil_drive, got.current_position, got.moving, got.status));
            return;
         end
         want = expected_q.pop_front();
         if (got.coil_drive !== want.coil_drive || got.current_position !== want.current_position
             || got.moving !== want.moving || got.status !== want.status)
            complain($sformatf({"expected coils %h pos %0d moving %b status %0d, ",
                                "got coils %h pos %0d moving %b status %0d"},
                               want.coil_drive, want.current_position, want.moving, want.status,
                               got.coil_drive, got.current_position, got.moving, got.status));
      endfunction
   endclass

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   psq_req_type req_item  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   psq_rsp_type rsp_item;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_wdata = 16'd0;

   int          cycle_count = 0;
   wire         calm = (cycle_count >= CALM_START) && (cycle_count < CALM_END);
   coil_tracker sb;

   stepper_phase_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 36);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_item);
   end

   function automatic psq_req_type mk(logic [2:0] cmd, logic [15:0] count, logic [11:0] cyc,
                                      logic [2:0] tgt);
      psq_req_type it;
      it.command         = cmd;
      it.step_count      = count;
      it.cycles          = cyc;
      it.target_position = tgt;
      return it;
   endfunction

   // Commands that would start a long move are sent only when they get rejected or fail.
   function automatic psq_req_type next_item();
      psq_req_type it;
      int          roll;
      int          span;
      int          turns;
      it   = mk(CMD_TICK, 16'($urandom), 12'($urandom), 3'($urandom));
      roll = $urandom_range(0, 99);
      span = (sb.pulse_cfg > LONG_PULSE) ? 0 : 6;
      if (sb.is_moving()) begin
         if (roll >= 96) it.command = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
         else if (roll >= 84) it.command = 3'($urandom_range(CMD_FWD, CMD_GOTO));
      end else if (roll >= 20) begin
         it.command = 3'($urandom_range(CMD_FWD, CMD_GOTO));
         if (sb.fits_mode(sb.pos)) begin
            turns         = (span == 0) ? 0 : int'($urandom_range(0, 4)) - 2;
            it.step_count = 16'($urandom_range(0, span));
            it.cycles     = 12'(turns);
         end
         if (span == 0 && it.command == CMD_GOTO) begin
            // aim outside the mode; where every position fits, send an empty cycle
            if (sb.mode_cfg == MODE_HALF) it.command = CMD_CYCLE;
            else it.target_position[0] = (sb.mode_cfg != MODE_TWO);
         end
      end else if (roll >= 15) begin
         it.command = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      end
      return it;
   endfunction

   task automatic send_item(psq_req_type it);
      while (!calm && $urandom_range(0, 99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      sb.note_item(it);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Tick the current move out, then let every result drain.
   task automatic settle();
      while (sb.is_moving())
         send_item(mk(CMD_TICK, 16'($urandom), 12'($urandom), 3'($urandom)));
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int          done_items;
      int          phase_no;
      int          quota;
      int          roll;
      logic [1:0]  mode;
      logic        hold;
      logic [15:0] pulse;
      logic [15:0] data;
      psq_req_type it;

      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // register defaults: wave mode, no hold, ten ticks per pulse
      send_item(mk(CMD_TICK, 16'd0, 12'd0, 3'd0));
      send_item(mk(CMD_UNUSED_LO, 16'hFFFF, 12'h7FF, 3'd7));
      send_item(mk(CMD_UNUSED_HI, 16'h0000, 12'h800, 3'd0));
      send_item(mk(CMD_FWD, 16'd0, 12'hFFF, 3'd7));
      send_item(mk(CMD_BWD, 16'd0, 12'h000, 3'd0));
      send_item(mk(CMD_CYCLE, 16'hFFFF, 12'd0, 3'd7));
      send_item(mk(CMD_GOTO, 16'd0, 12'd0, 3'd7));
      send_item(mk(CMD_GOTO, 16'd0, 12'd0, 3'd2));
      send_item(mk(CMD_FWD, 16'hFFFF, 12'h7FF, 3'd0));
      send_item(mk(CMD_CYCLE, 16'd0, 12'h800, 3'd0));
      send_item(mk(CMD_BWD, 16'hFFFF, 12'hFFF, 3'd7));
      send_item(mk(CMD_GOTO, 16'd0, 12'd0, 3'd4));
      settle();

      phase_no   = 0;
      done_items = 0;
      while (done_items < RANDOM_ITEMS) begin
         case (phase_no)
            0: begin mode = MODE_HALF; hold = 1'b1; pulse = 16'd1;     end
            1: begin mode = MODE_TWO;  hold = 1'b0; pulse = 16'd0;     end
            2: begin mode = MODE_NONE; hold = 1'b1; pulse = 16'd2;     end
            3: begin mode = MODE_WAVE; hold = 1'b1; pulse = 16'hFFFF;  end
            4: begin mode = MODE_WAVE; hold = 1'b0; pulse = 16'd3;     end
            default: begin
               mode  = 2'($urandom_range(0, 3));
               hold  = 1'($urandom_range(0, 1));
               roll  = $urandom_range(0, 99);
               pulse = (roll < 10) ? 16'd0 :
                       (roll < 80) ? 16'($urandom_range(1, 4)) : 16'($urandom_range(5, 40));
            end
         endcase
         // upper bits of the narrow registers carry noise
         data = 16'($urandom);
         data[1:0] = mode;
         write_csr(REG_STEP_MODE, data);
         data = 16'($urandom);
         data[0] = hold;
         write_csr(REG_HOLD_ENABLE, data);
         write_csr(REG_PULSE_TICKS, pulse);
         if ($urandom_range(0, 3) == 0) write_csr(REG_SPARE, 16'($urandom));

         quota = (pulse > LONG_PULSE) ? 8 : $urandom_range(40, 80);
         while (quota > 0) begin
            it = next_item();
            send_item(it);
            if (it.command <= CMD_GOTO) begin
               quota--;
               done_items++;
            end
         end
         settle();
         phase_no++;
      end

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
